// ===== rtl/tsf_pkg.sv =====
// Shared widths, types and scaling constants of the temperature slew filter.
// No dependencies; every other file of the block takes this package first.
`timescale 1ns / 1ps
`default_nettype none

package tsf_pkg;

    // Field widths.
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned TEMP_W   = 14;

    // Scaling: (sample - 1855) * 6670 / 4096, truncated toward zero.
    localparam int unsigned DIFF_W      = SAMPLE_W + 1;
    localparam int unsigned PROD_W      = 26;
    localparam int unsigned SCALE_SHIFT = 12;

    localparam logic signed [DIFF_W-1:0] SCALE_ZERO = DIFF_W'(1855);
    localparam logic signed [PROD_W-1:0] SCALE_MUL  = PROD_W'(6670);
    // Bias added to negative products so the arithmetic shift rounds toward zero.
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << SCALE_SHIFT) - 1);

    typedef logic        [SAMPLE_W-1:0] t_sample;
    typedef logic signed [OFFSET_W-1:0] t_offset;
    typedef logic signed [TEMP_W-1:0]   t_temp;

endpackage

`default_nettype wire

// ===== rtl/tsf_in_if.sv =====
// Input channel of the temperature slew filter: one sample beat.
// Depends on tsf_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

interface tsf_in_if;
    logic             valid;
    logic             ready;
    tsf_pkg::t_sample sensor_sample;
    logic             slew_en;

    modport source (output valid, output sensor_sample, output slew_en, input ready);
    modport sink   (input valid, input sensor_sample, input slew_en, output ready);
endinterface

`default_nettype wire

// ===== rtl/tsf_out_if.sv =====
// Result channel of the temperature slew filter: one result beat per sample.
// Depends on tsf_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

interface tsf_out_if;
    logic           valid;
    logic           ready;
    tsf_pkg::t_temp measured_value;
    tsf_pkg::t_temp filtered_reading;
    tsf_pkg::t_temp maximum_seen;
    tsf_pkg::t_temp minimum_seen;

    modport source (output valid, output measured_value, output filtered_reading,
                    output maximum_seen, output minimum_seen, input ready);
    modport sink   (input valid, input measured_value, input filtered_reading,
                    input maximum_seen, input minimum_seen, output ready);
endinterface

`default_nettype wire

// ===== rtl/tsf_cfg_if.sv =====
// Configuration write channel of the temperature slew filter.
// Depends on tsf_pkg for the offset type.
`timescale 1ns / 1ps
`default_nettype none

interface tsf_cfg_if;
    logic             valid;
    logic             ready;
    tsf_pkg::t_offset calibration_offset;

    modport source (output valid, output calibration_offset, input ready);
    modport sink   (input valid, input calibration_offset, output ready);
endinterface

`default_nettype wire

// ===== rtl/temperature_slew_filter_minmax_core.sv =====
// Top level of the temperature slew filter with running minimum and maximum.
// Depends on tsf_pkg, tsf_in_if, tsf_out_if, tsf_cfg_if and tsf_scale.
`timescale 1ns / 1ps
`default_nettype none

// The block accepts one sample beat every clock cycle unless the output stalls,
// and delivers one result beat for each, in order, from the output register.
// The first stage scales the sample and adds the calibration offset (one 13 by
// 14 bit multiply); the second stage steps the filtered reading and updates
// the running extremes, and loads the output register in the same cycle. The
// output register holds its beat while the sink stalls, and a sample already
// in the first stage waits behind it. Configuration writes are taken in every
// cycle and must only be issued while no beat is in flight.
module temperature_slew_filter_minmax_core (
    input  wire   i_clk,
    input  wire   i_rst_n,
    tsf_in_if.sink    i_sample,
    tsf_cfg_if.sink   i_cfg,
    tsf_out_if.source o_result
);

    // Configuration register.
    tsf_pkg::t_offset r_offset;

    // Scaling stage.
    logic             r_a_valid;
    tsf_pkg::t_temp   r_a_meas;
    logic             r_a_filt;
    tsf_pkg::t_temp   scaled;
    logic             a_load;

    // Filter state.
    tsf_pkg::t_temp   r_reading;
    tsf_pkg::t_temp   r_max;
    tsf_pkg::t_temp   r_min;
    logic             r_extremes_valid;
    tsf_pkg::t_temp   n_reading;
    tsf_pkg::t_temp   n_max;
    tsf_pkg::t_temp   n_min;
    logic             b_load;

    // Output register.
    logic             r_out_valid;
    tsf_pkg::t_temp   r_out_meas;

    // Offset register; writes are always accepted.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg.valid) begin
            r_offset <= i_cfg.calibration_offset;
        end
    end

    // Handshake: the second stage advances when the output register is free
    // or being emptied, and the first stage refills behind it.
    assign b_load         = r_a_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_a_valid || b_load;
    assign a_load         = i_sample.valid && i_sample.ready;

    tsf_scale u_scale (
        .i_sample   (i_sample.sensor_sample),
        .i_offset   (r_offset),
        .o_measured (scaled)
    );

    // First stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_load) begin
            r_a_valid <= 1'b1;
        end else if (b_load) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_meas <= scaled;
            r_a_filt <= i_sample.slew_en;
        end
    end

    // Slew step or direct load of the reading, and the running extremes.
    always_comb begin
        if (!r_a_filt) begin
            n_reading = r_a_meas;
        end else if (r_a_meas > r_reading) begin
            n_reading = r_reading + tsf_pkg::TEMP_W'(1);
        end else if (r_a_meas < r_reading) begin
            n_reading = r_reading - tsf_pkg::TEMP_W'(1);
        end else begin
            n_reading = r_reading;
        end

        if (!r_extremes_valid || r_a_meas > r_max) begin
            n_max = r_a_meas;
        end else begin
            n_max = r_max;
        end

        if (!r_extremes_valid || r_a_meas < r_min) begin
            n_min = r_a_meas;
        end else begin
            n_min = r_min;
        end
    end

    // Filter state updates as each beat moves into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading        <= '0;
            r_max            <= '0;
            r_min            <= '0;
            r_extremes_valid <= 1'b0;
        end else if (b_load) begin
            r_reading        <= n_reading;
            r_max            <= n_max;
            r_min            <= n_min;
            r_extremes_valid <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_out_meas <= r_a_meas;
        end
    end

    // The state registers already hold the values after the delivered beat.
    assign o_result.valid            = r_out_valid;
    assign o_result.measured_value   = r_out_meas;
    assign o_result.filtered_reading = r_reading;
    assign o_result.maximum_seen     = r_max;
    assign o_result.minimum_seen     = r_min;

endmodule

`default_nettype wire

// ===== rtl/tsf_scale.sv =====
// Converts a raw sensor sample to tenths of a degree and adds the offset.
// Depends on tsf_pkg for widths and scaling constants.
`timescale 1ns / 1ps
`default_nettype none

module tsf_scale (
    input  wire tsf_pkg::t_sample i_sample,
    input  wire tsf_pkg::t_offset i_offset,
    output tsf_pkg::t_temp        o_measured
);

    logic signed [tsf_pkg::DIFF_W-1:0] diff;
    logic signed [tsf_pkg::PROD_W-1:0] product;
    logic signed [tsf_pkg::PROD_W-1:0] biased;
    logic signed [tsf_pkg::PROD_W-1:0] shifted;

    // Remove the zero point, then multiply by the scale factor.
    assign diff    = $signed({1'b0, i_sample}) - tsf_pkg::SCALE_ZERO;
    assign product = tsf_pkg::PROD_W'(diff) * tsf_pkg::SCALE_MUL;

    // Divide by 4096 with truncation toward zero.
    assign biased  = product + (product[tsf_pkg::PROD_W-1] ? tsf_pkg::ROUND_BIAS
                                                          : tsf_pkg::PROD_W'(0));
    assign shifted = biased >>> tsf_pkg::SCALE_SHIFT;

    // Apply the signed calibration offset; the sum always fits the result width.
    assign o_measured = $signed(shifted[tsf_pkg::TEMP_W-1:0])
                      + tsf_pkg::TEMP_W'(i_offset);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for temperature_slew_filter_minmax_core.
// Depends on tsf_pkg and the tsf_in_if, tsf_out_if and tsf_cfg_if interfaces.
`timescale 1ns / 1ps

module testbench;

    // Scaling constants of the temperature conversion, in tenths of a degree.
    localparam int SENSOR_ZERO = 1855;
    localparam int TENTHS_MUL  = 6670;
    localparam int SCALE_DIV   = 4096;

    localparam int RESET_CYCLES     = 11;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES      = 8;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_SAMPLES    = 82;

    localparam tsf_pkg::t_offset OFFSET_MIN = -12'sd2048;
    localparam tsf_pkg::t_offset OFFSET_MAX = 12'sd2047;

    typedef struct packed {
        tsf_pkg::t_temp measured;
        tsf_pkg::t_temp filtered;
        tsf_pkg::t_temp maximum;
        tsf_pkg::t_temp minimum;
    } t_temp_result;

    logic clk;
    logic rst_n;

    tsf_in_if  sample_if ();
    tsf_cfg_if cfg_if ();
    tsf_out_if result_if ();

    temperature_slew_filter_minmax_core i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (sample_if),
        .i_cfg    (cfg_if),
        .o_result (result_if)
    );

    // Predicted filter state, kept in step with every accepted beat.
    tsf_pkg::t_offset cal_offset     = '0;
    int               slewed_reading = 0;
    int               hottest        = 0;
    int               coldest        = 0;
    bit               have_extremes  = 1'b0;

    t_temp_result pending_temps[$];
    t_temp_result due_temp;
    int           error_count = 0;

    // Sender and receiver pacing controls.
    bit sender_steady     = 1'b0;
    int burst_left        = 0;
    bit long_hold_pending = 1'b0;

    // Clock with a 2 ns period.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Scale one sample, then step the reading and the extremes.
    function automatic t_temp_result predict_temperature(input tsf_pkg::t_sample raw,
                                                         input logic slew_on);
        int           measured;
        t_temp_result res;
        measured = ((int'(raw) - SENSOR_ZERO) * TENTHS_MUL) / SCALE_DIV
                   + int'(cal_offset);
        if (slew_on) begin
            if (measured > slewed_reading) slewed_reading++;
            else if (measured < slewed_reading) slewed_reading--;
        end else begin
            slewed_reading = measured;
        end
        if (!have_extremes) begin
            hottest       = measured;
            coldest       = measured;
            have_extremes = 1'b1;
        end else begin
            if (measured > hottest) hottest = measured;
            if (measured < coldest) coldest = measured;
        end
        res.measured = tsf_pkg::t_temp'(measured);
        res.filtered = tsf_pkg::t_temp'(slewed_reading);
        res.maximum  = tsf_pkg::t_temp'(hottest);
        res.minimum  = tsf_pkg::t_temp'(coldest);
        return res;
    endfunction

    task automatic check_field(input string field, input tsf_pkg::t_temp want,
                               input tsf_pkg::t_temp got);
        if (want !== got) begin
            $display("%0t %s: expected %0d, actual %0d", $time, field,
                     $signed(want), $signed(got));
            error_count++;
        end
    endtask

    // Watch all three channels: track the offset, predict, and compare results.
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_if.valid && cfg_if.ready)
                cal_offset = cfg_if.calibration_offset;
            if (sample_if.valid && sample_if.ready)
                pending_temps.push_back(predict_temperature(sample_if.sensor_sample,
                                                            sample_if.slew_en));
            if (result_if.valid && result_if.ready) begin
                if (pending_temps.size() == 0) begin
                    $display("%0t result beat with none expected: measured %0d",
                             $time, $signed(result_if.measured_value));
                    error_count++;
                end else begin
                    due_temp = pending_temps.pop_front();
                    check_field("measured_value", due_temp.measured,
                                result_if.measured_value);
                    check_field("filtered_reading", due_temp.filtered,
                                result_if.filtered_reading);
                    check_field("maximum_seen", due_temp.maximum,
                                result_if.maximum_seen);
                    check_field("minimum_seen", due_temp.minimum,
                                result_if.minimum_seen);
                end
            end
        end
    end

    // Result receiver: changes its stall pattern every so often, and holds off
    // for a long stretch when asked to.
    initial begin
        int stall_mode;
        int mode_left;
        int cycle_no;
        stall_mode = 0;
        mode_left  = 0;
        cycle_no   = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            cycle_no++;
            if (long_hold_pending) begin
                long_hold_pending <= 1'b0;
                result_if.ready   <= 1'b0;
                for (int n = 0; n < LONG_HOLD_CYCLES; n++)
                    @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 100);
                end
                mode_left--;
                case (stall_mode)
                    0: result_if.ready <= 1'b1;
                    1: result_if.ready <= 1'($urandom_range(0, 1));
                    2: result_if.ready <= ($urandom_range(0, 3) != 0);
                    default: result_if.ready <= (cycle_no % 5 != 0);
                endcase
            end
        end
    end

    // Send one sample beat; between bursts the sender leaves a random gap unless it is set steady.
    task automatic send_sample(input tsf_pkg::t_sample raw, input logic slew_on);
        sample_if.valid         <= 1'b1;
        sample_if.sensor_sample <= raw;
        sample_if.slew_en       <= slew_on;
        do @(posedge clk); while (!sample_if.ready);
        if (!sender_steady) begin
            if (burst_left == 0) begin
                sample_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic wait_drained();
        sample_if.valid <= 1'b0;
        do @(posedge clk); while (pending_temps.size() != 0);
    endtask

    // Write the calibration offset; the block must be idle.
    task automatic write_offset(input tsf_pkg::t_offset value);
        wait_drained();
        cfg_if.valid              <= 1'b1;
        cfg_if.calibration_offset <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // First samples after reset: the reading steps from zero, extremes load.
    task automatic test_reset_first_sample();
        send_sample(12'hFFF, 1'b1);
        send_sample(12'hFFF, 1'b1);
        send_sample(12'h000, 1'b0);
    endtask

    // Scale end points, zero crossing, equal value with the filter on.
    task automatic test_scaling_extremes();
        send_sample(tsf_pkg::t_sample'(SENSOR_ZERO), 1'b0);
        send_sample(tsf_pkg::t_sample'(SENSOR_ZERO), 1'b1);
        send_sample(tsf_pkg::t_sample'(SENSOR_ZERO - 1), 1'b1);
        send_sample(tsf_pkg::t_sample'(SENSOR_ZERO + 1), 1'b1);
        send_sample(12'h000, 1'b1);
        send_sample(12'hFFF, 1'b0);
        send_sample(12'hFFF, 1'b1);
        send_sample(12'h555, 1'b0);
        send_sample(12'hAAA, 1'b1);
        send_sample(12'h800, 1'b0);
        send_sample(12'h7FF, 1'b1);
    endtask

    // Offset at both ends of its 12-bit range, including beyond the nominal span.
    task automatic test_offset_extremes();
        write_offset(OFFSET_MIN);
        send_sample(12'h000, 1'b0);
        send_sample(12'hFFF, 1'b1);
        write_offset(OFFSET_MAX);
        send_sample(12'hFFF, 1'b0);
        send_sample(12'h000, 1'b1);
        write_offset(12'sd2000);
        send_sample(12'hFFF, 1'b0);
        write_offset(-12'sd2000);
        send_sample(12'h000, 1'b0);
        write_offset('0);
        send_sample(tsf_pkg::t_sample'(SENSOR_ZERO), 1'b0);
    endtask

    // The receiver holds off for a long stretch while samples keep coming,
    // so the block fills up and stalls its input.
    task automatic test_output_holdoff();
        wait_drained();
        sender_steady     = 1'b1;
        long_hold_pending <= 1'b1;
        for (int n = 0; n < 20; n++)
            send_sample(tsf_pkg::t_sample'($urandom_range(0, 4095)), 1'(n % 2));
        wait_drained();
        sender_steady = 1'b0;
    endtask

    // Random phases, each under its own offset: mostly a direct load followed
    // by a run of filtered samples near it, so the reading settles, with
    // unrelated samples mixed in.
    task automatic test_random_traffic();
        int               sent;
        int               run_len;
        int               base;
        tsf_pkg::t_offset phase_offset;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: phase_offset = OFFSET_MAX;
                1: phase_offset = OFFSET_MIN;
                default: phase_offset = tsf_pkg::t_offset'($urandom_range(0, 4095));
            endcase
            write_offset(phase_offset);
            sender_steady = (phase % 3 == 2);
            sent = 0;
            while (sent < PHASE_SAMPLES) begin
                if ($urandom_range(0, 9) < 6) begin
                    base    = $urandom_range(2, 4093);
                    run_len = $urandom_range(4, 12);
                    send_sample(tsf_pkg::t_sample'(base), 1'b0);
                    for (int n = 0; n < run_len; n++)
                        send_sample(tsf_pkg::t_sample'(base + $urandom_range(0, 4) - 2),
                                    1'b1);
                    sent += run_len + 1;
                end else if ($urandom_range(0, 4) == 0) begin
                    send_sample($urandom_range(0, 1) ? 12'hFFF : 12'h000,
                                1'($urandom_range(0, 1)));
                    sent++;
                end else begin
                    send_sample(tsf_pkg::t_sample'($urandom_range(0, 4095)),
                                1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            sender_steady = 1'b0;
        end
    endtask

    // Test sequence.
    initial begin
        rst_n                     <= 1'b0;
        sample_if.valid           <= 1'b0;
        sample_if.sensor_sample   <= '0;
        sample_if.slew_en         <= 1'b0;
        cfg_if.valid              <= 1'b0;
        cfg_if.calibration_offset <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_first_sample();
        test_scaling_extremes();
        test_offset_extremes();
        test_output_holdoff();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_temps.size() == 0)
            $display("temperature_slew_filter_minmax_core: match");
        else
            $display("temperature_slew_filter_minmax_core: mismatch");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #400000;
        $display("temperature_slew_filter_minmax_core: mismatch");
        $finish;
    end

endmodule
